>>> sv/msbbp_pkg.sv
// ----------------------------------------------------------------------------
// msbbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msbbp_pkg;

  localparam int ValueBits  = 31;
  localparam int WidthBits  = 5;
  localparam int ByteBits   = 8;
  localparam int AlignBits  = ValueBits + 1;       // left-aligned field
  localparam int AccBits    = AlignBits + ByteBits; // pending byte plus field
  localparam int TotalBits  = 6;                    // up to 7 + 31 bits
  localparam int FillBits   = 3;                    // pending bit count 0..7
  localparam int InDataBits = 40;                   // value and width, padded

  // One classified field waiting for the back end
  typedef struct packed {
    logic [AlignBits-1:0] aligned; // field bits, first bit in the MSB
    logic [WidthBits-1:0] nbits;
    logic                 flush;
  } qent_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/msbbp_queue.sv
// ----------------------------------------------------------------------------
// msbbp_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbbp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire msbbp_pkg::qent_t wr_ent,
  output logic                 full,
  input  wire logic            pop,
  output msbbp_pkg::qent_t     rd_ent,
  output logic                 empty
);
  import msbbp_pkg::*;

  qent_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_ent = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/msbbp_front.sv
// ----------------------------------------------------------------------------
// msbbp_front
// Accepts input transactions, masks the field to its width and aligns it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbbp_front (
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [msbbp_pkg::InDataBits-1:0]    s_tdata,
  input  wire logic                                s_tlast,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output msbbp_pkg::qent_t                         q_ent
);
  import msbbp_pkg::*;

  logic [ValueBits-1:0] value;
  logic [WidthBits-1:0] width;
  logic                 flush;
  logic [ValueBits-1:0] masked;
  logic [WidthBits-1:0] lshift;

  assign value = s_tdata[ValueBits-1:0];
  assign width = s_tdata[ValueBits +: WidthBits];
  assign flush = s_tlast;

  // handshake
  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

  // keep only the low width bits, then move the first bit to the top
  assign masked = value & ~({ValueBits{1'b1}} << width);
  assign lshift = WidthBits'(ValueBits) - width;

  always_comb begin
    q_ent.aligned = {masked, 1'b0} << lshift;
    q_ent.nbits   = width;
    q_ent.flush   = flush;
  end

endmodule

`default_nettype wire

>>> sv/msbbp_back.sv
// ----------------------------------------------------------------------------
// msbbp_back
// Merges a queued field with the pending byte and emits bytes one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbbp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire msbbp_pkg::qent_t              q_ent,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [msbbp_pkg::ByteBits-1:0]     m_tdata,
  output logic                               m_tlast
);
  import msbbp_pkg::*;

  back_state_t          state, state_next;
  logic [AccBits-1:0]   acc, acc_next;
  logic [TotalBits-1:0] total, total_next;
  logic                 flush_r, flush_r_next;
  logic [ByteBits-1:0]  pend_byte, pend_byte_next;
  logic [FillBits-1:0]  pend_cnt, pend_cnt_next;
  logic                 out_load;
  logic                 out_last;
  logic                 out_free;
  logic                 has_full;
  logic                 emit;
  logic [TotalBits-1:0] rem;
  logic                 is_last;

  assign out_free = ~m_tvalid | m_tready;
  assign has_full = (total >= TotalBits'(ByteBits));
  assign emit     = has_full | (flush_r & (total != '0));
  assign rem      = has_full ? total - TotalBits'(ByteBits) : '0;
  assign is_last  = (rem == '0) | ((rem < TotalBits'(ByteBits)) & ~flush_r);

  // next state and datapath control
  always_comb begin
    state_next     = state;
    acc_next       = acc;
    total_next     = total;
    flush_r_next   = flush_r;
    pend_byte_next = pend_byte;
    pend_cnt_next  = pend_cnt;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    out_last       = 1'b0;
    case (state)
      BACK_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          acc_next     = {pend_byte, {AlignBits{1'b0}}}
                         | ({q_ent.aligned, {ByteBits{1'b0}}} >> pend_cnt);
          total_next   = TotalBits'(pend_cnt) + TotalBits'(q_ent.nbits);
          flush_r_next = q_ent.flush;
          state_next   = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (emit) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_last   = is_last;
            acc_next   = acc << ByteBits;
            total_next = rem;
            if (is_last) begin
              pend_byte_next = acc[AccBits-ByteBits-1 -: ByteBits];
              pend_cnt_next  = rem[FillBits-1:0];
              state_next     = BACK_IDLE;
            end
          end
        end else begin
          // nothing to send, keep the partial byte
          pend_byte_next = acc[AccBits-1 -: ByteBits];
          pend_cnt_next  = total[FillBits-1:0];
          state_next     = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      pend_byte <= '0;
      pend_cnt  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      pend_byte <= pend_byte_next;
      pend_cnt  <= pend_cnt_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    acc     <= acc_next;
    total   <= total_next;
    flush_r <= flush_r_next;
    if (out_load) begin
      m_tdata <= acc[AccBits-1 -: ByteBits];
      m_tlast <= out_last;
    end
  end

endmodule

`default_nettype wire

>>> sv/msb_first_bit_packer_unit.sv
// Flow: an accepted item is written into the queue, the back end pops it into its
//   accumulator, and its first byte is then registered onto the output.
// Output: one byte per cycle while m_tready does not hold the output; the two-entry
//   queue lets the front keep accepting items while the back end emits earlier ones.
// Reset: synchronous; clears the queue, the pending byte (empty) and output valid.
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// Packs fields of 0 to 31 bits MSB first into a byte stream, with flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_packer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [30:0] value, [35:31] width, [39:36] zero
  input  wire logic [msbbp_pkg::InDataBits-1:0]    s_tdata,
  input  wire logic                                s_tlast,  // flush
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [7:0] out_byte
  output logic [msbbp_pkg::ByteBits-1:0]           m_tdata,
  output logic                                     m_tlast
);
  import msbbp_pkg::*;

  qent_t wr_ent;
  qent_t rd_ent;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // accept and align
  msbbp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ent    (wr_ent)
  );

  // decoupling queue
  msbbp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_ent (wr_ent),
    .full   (q_full),
    .pop    (q_pop),
    .rd_ent (rd_ent),
    .empty  (q_empty)
  );

  // byte emission
  msbbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_ent    (rd_ent),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
